/* src/life_generation_stencil_defines.svh */
// Assertion macros shared by the checker of the life generation stencil.
`ifndef LIFE_GENERATION_STENCIL_DEFINES_SVH
`define LIFE_GENERATION_STENCIL_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define LGS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define LGS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lgs_pkg.sv */
// Shared constants, types and helper functions of the life generation stencil.
package lgs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int OUT_POS_W  = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int NUM_STORES = 3;
  localparam int NUM_SLOTS  = 4;
  localparam int DIM_RESET  = 64;

  typedef logic [COL_W-1:0]     col_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [OUT_POS_W-1:0] opos_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

  // Neighbour counts of rule B3/S23.
  localparam logic [3:0] NB_SURVIVE = 4'd2;
  localparam logic [3:0] NB_BIRTH   = 4'd3;

  // Offsets from the current store to the stores of the two rows above.
  localparam logic [1:0] OFF_PREV  = 2'd2;
  localparam logic [1:0] OFF_OLDER = 2'd1;

  // Result slots of one request, in the order in which they leave.
  typedef enum logic [1:0] {
    SLOT_ABOVE_PREV,
    SLOT_ABOVE_END,
    SLOT_LAST_PREV,
    SLOT_LAST_END
  } slot_t;

  // Window reload after a width change pulled the column back.
  typedef enum logic [1:0] {
    RS_IDLE,
    RS_READ_LEFT2,
    RS_READ_LEFT1,
    RS_LOAD
  } resync_state_t;

  // One column of the window: rows r-2, r-1 and r.
  typedef struct packed {
    logic older;
    logic prev;
    logic cur;
  } column_t;

  function automatic logic [1:0] store_index(input logic [1:0] rot, input logic [1:0] off);
    logic [2:0] sum;
    sum = 3'(rot) + 3'(off);
    if (sum >= 3'd3) begin
      sum = sum - 3'd3;
    end
    return sum[1:0];
  endfunction

  // Next state of the centre cell of a 3x3 neighbourhood.
  function automatic logic life_rule(input logic [2:0] above, input logic [2:0] centre,
                                     input logic [2:0] below);
    logic [3:0] n;
    n = 4'(above[0]) + 4'(above[1]) + 4'(above[2]) + 4'(centre[0]) + 4'(centre[2])
      + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);
    return centre[1] ? (n == NB_SURVIVE || n == NB_BIRTH) : (n == NB_BIRTH);
  endfunction

endpackage

/* src/lgs_in_if.sv */
// Input stream channel: one current-generation cell per request.
interface lgs_in_if import lgs_pkg::*; ();
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, output cell_alive, input ready);
  modport sink (input valid, input cell_alive, output ready);
endinterface

/* src/lgs_out_if.sv */
// Result stream channel: one next-generation cell with its position per request.
interface lgs_out_if import lgs_pkg::*; ();
  logic  valid;
  logic  ready;
  opos_t out_row;
  opos_t out_col;
  logic  next_alive;
  logic  last_of_run;
  logic  frame_done;

  modport source (output valid, output out_row, output out_col, output next_alive,
                  output last_of_run, output frame_done, input ready);
  modport sink (input valid, input out_row, input out_col, input next_alive,
                input last_of_run, input frame_done, output ready);
endinterface

/* src/life_generation_stencil.sv */
// Top level of the life generation stencil: raster stream in, next generation out.
//
// Channel   Dir  Payload                                         Request taken when
// in_chan   in   cell_alive                                      valid && ready
// out_chan  out  out_row, out_col, next_alive,                   valid && ready
//                last_of_run, frame_done
// cfg_*     in   cfg_index (0 grid_width, 1 grid_height),        cfg_we high
//                cfg_wdata
//
// An interior request yields at most one result; at a row end and along the last row it
// yields up to two (up to four for the final cell), and the single result port sets the
// pace of one result per cycle while out_chan.ready is high. The row stores are three
// 1-bit RAMs with a registered read, so a request's results pass the second stage and the
// result register before they appear. Reset needs no clearing pass. After a width write
// that leaves the column beyond the new width, the input waits while the two columns to its left are reread.
module life_generation_stencil import lgs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lgs_in_if.sink               in_chan,
  lgs_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers and their clamped values.
  // ---------------------------------------------------------------------------
  dim_t grid_width_r;
  dim_t grid_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_W'(DIM_RESET);
      grid_height_r <= DIM_W'(DIM_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        REG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
      endcase
    end
  end

  dim_t w_eff;
  dim_t h_eff;
  col_t w_last;
  row_t h_last;

  // Zero or oversized dimensions are clamped into the supported range.
  always_comb begin
    priority if (grid_width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (grid_width_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width_r;
    end
    priority if (grid_height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (grid_height_r > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height_r;
    end
    w_last = COL_W'(w_eff - DIM_W'(1));
    h_last = ROW_W'(h_eff - DIM_W'(1));
  end

  // ---------------------------------------------------------------------------
  // Raster position. A position beyond the grid (possible only after a register
  // write) is pulled back to the last column or row before it is used.
  // ---------------------------------------------------------------------------
  col_t          col_r;
  col_t          col_nxt;
  row_t          row_r;
  row_t          row_nxt;
  logic [1:0]    rot_r;
  logic [1:0]    rot_nxt;
  col_t          col_sat;
  row_t          row_sat;
  logic          need_resync;
  logic          row_end;
  logic          last_row;

  assign need_resync = (DIM_W'(col_r) >= w_eff);
  assign col_sat     = need_resync ? w_last : col_r;
  assign row_sat     = (DIM_W'(row_r) >= h_eff) ? h_last : row_r;
  assign row_end     = (col_sat == w_last);
  assign last_row    = (row_sat == h_last);

  // ---------------------------------------------------------------------------
  // Window reload sequencer. When the column was pulled back, the two columns to
  // its left no longer sit in the window registers, so they are read again from
  // all three stores before the next request is taken.
  // ---------------------------------------------------------------------------
  resync_state_t rs_state_r;
  resync_state_t rs_state_nxt;
  logic          s1_v_r;
  logic          rs_rd;
  col_t          rs_addr;
  logic          win2_from_ram;
  logic          win1_from_ram;
  logic          rs_commit;

  always_comb begin
    unique case (rs_state_r)
      RS_IDLE:       rs_state_nxt = (need_resync && !s1_v_r) ? RS_READ_LEFT2 : RS_IDLE;
      RS_READ_LEFT2: rs_state_nxt = RS_READ_LEFT1;
      RS_READ_LEFT1: rs_state_nxt = RS_LOAD;
      RS_LOAD:       rs_state_nxt = RS_IDLE;
    endcase
  end

  always_comb begin
    rs_rd         = 1'b0;
    rs_addr       = col_sat;
    win2_from_ram = 1'b0;
    win1_from_ram = 1'b0;
    rs_commit     = 1'b0;
    unique case (rs_state_r)
      RS_IDLE: begin
      end
      RS_READ_LEFT2: begin
        rs_rd   = 1'b1;
        rs_addr = col_sat - COL_W'(2);
      end
      RS_READ_LEFT1: begin
        rs_rd         = 1'b1;
        rs_addr       = col_sat - COL_W'(1);
        win2_from_ram = 1'b1;
      end
      RS_LOAD: begin
        win1_from_ram = 1'b1;
        rs_commit     = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Row stores. The store picked by the rotation takes the incoming cell; all
  // three are read at the same column so that the bits of the other two arrive
  // together with the request in the second stage.
  // ---------------------------------------------------------------------------
  logic                  in_fire;
  logic                  ram_re;
  col_t                  ram_raddr;
  logic [NUM_STORES-1:0] rd_bits;

  assign ram_re    = in_fire || rs_rd;
  assign ram_raddr = rs_rd ? rs_addr : col_sat;

  for (genvar k = 0; k < NUM_STORES; k++) begin : g_store
    lgs_ram #(
      .WIDTH(1),
      .DEPTH(MAX_WIDTH)
    ) u_store (
      .clk   (clk),
      .we    (in_fire && (rot_r == 2'(k))),
      .waddr (col_sat),
      .wdata (in_chan.cell_alive),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rd_bits[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Second stage: the request whose store bits have just come back.
  // ---------------------------------------------------------------------------
  logic       s1_v_nxt;
  logic       s1_cell_r;
  row_t       s1_row_r;
  col_t       s1_col_r;
  logic       s1_row_end_r;
  logic       s1_last_row_r;
  logic [1:0] s1_rot_r;

  logic [1:0] rot_sel;
  column_t    col_rd;
  column_t    win1_r;
  column_t    win2_r;
  column_t    col_a;
  column_t    col_b;
  column_t    col_c;
  logic       has_prev;
  logic       has_older;
  logic       has_left;

  assign rot_sel = (rs_state_r == RS_IDLE) ? s1_rot_r : rot_r;

  always_comb begin
    col_rd.older = rd_bits[store_index(rot_sel, OFF_OLDER)];
    col_rd.prev  = rd_bits[store_index(rot_sel, OFF_PREV)];
    col_rd.cur   = rd_bits[rot_sel];
  end

  // Columns c-2 (a), c-1 (b) and c (c); columns left of the grid are dead.
  assign has_left  = (s1_col_r != '0);
  assign has_prev  = (s1_row_r != '0);
  assign has_older = (s1_row_r >= ROW_W'(2));
  assign col_a     = (s1_col_r >= COL_W'(2)) ? win2_r : '0;
  assign col_b     = has_left ? win1_r : '0;

  always_comb begin
    col_c.older = col_rd.older;
    col_c.prev  = col_rd.prev;
    col_c.cur   = s1_cell_r;
  end

  logic [NUM_SLOTS-1:0] s1_alive;
  logic [NUM_SLOTS-1:0] s1_mask;
  logic [2:0]           older_prev_cell;
  logic [2:0]           prev_prev_cell;
  logic [2:0]           cur_prev_cell;
  logic [2:0]           older_end_cell;
  logic [2:0]           prev_end_cell;
  logic [2:0]           cur_end_cell;

  // Rows r-2, r-1 and r of the neighbourhood around column c-1, and around
  // column c at a row end, where the right-hand neighbour lies outside the grid.
  assign older_prev_cell = {col_a.older, col_b.older, col_c.older} & {3{has_older}};
  assign prev_prev_cell  = {col_a.prev, col_b.prev, col_c.prev};
  assign cur_prev_cell   = {col_a.cur, col_b.cur, col_c.cur};
  assign older_end_cell  = {col_b.older, col_c.older, 1'b0} & {3{has_older}};
  assign prev_end_cell   = {col_b.prev, col_c.prev, 1'b0};
  assign cur_end_cell    = {col_b.cur, col_c.cur, 1'b0};

  // In the last row the row below lies outside the grid.
  always_comb begin
    s1_alive[SLOT_ABOVE_PREV] = life_rule(older_prev_cell, prev_prev_cell, cur_prev_cell);
    s1_alive[SLOT_ABOVE_END]  = life_rule(older_end_cell, prev_end_cell, cur_end_cell);
    s1_alive[SLOT_LAST_PREV]  = life_rule(prev_prev_cell & {3{has_prev}}, cur_prev_cell, 3'b0);
    s1_alive[SLOT_LAST_END]   = life_rule(prev_end_cell & {3{has_prev}}, cur_end_cell, 3'b0);
    s1_mask[SLOT_ABOVE_PREV]  = has_prev && has_left;
    s1_mask[SLOT_ABOVE_END]   = has_prev && s1_row_end_r;
    s1_mask[SLOT_LAST_PREV]   = s1_last_row_r && has_left;
    s1_mask[SLOT_LAST_END]    = s1_last_row_r && s1_row_end_r;
  end

  // ---------------------------------------------------------------------------
  // Result register: holds the pending results of one request and hands them
  // out one per accepted request on the result channel.
  // ---------------------------------------------------------------------------
  logic                 b_v_r;
  logic                 b_v_nxt;
  logic [NUM_SLOTS-1:0] b_mask_r;
  logic [NUM_SLOTS-1:0] b_mask_nxt;
  logic [NUM_SLOTS-1:0] b_alive_r;
  logic [NUM_SLOTS-1:0] b_rest;
  row_t                 b_row_r;
  col_t                 b_col_r;
  slot_t                b_slot;
  logic                 b_last;
  logic                 b_free;
  logic                 b_load;
  logic                 out_fire;
  logic                 s1_done;
  row_t                 res_row;
  col_t                 res_col;

  always_comb begin
    priority if (b_mask_r[SLOT_ABOVE_PREV]) begin
      b_slot = SLOT_ABOVE_PREV;
    end else if (b_mask_r[SLOT_ABOVE_END]) begin
      b_slot = SLOT_ABOVE_END;
    end else if (b_mask_r[SLOT_LAST_PREV]) begin
      b_slot = SLOT_LAST_PREV;
    end else begin
      b_slot = SLOT_LAST_END;
    end
  end

  assign b_rest   = b_mask_r & ~(NUM_SLOTS'(1) << b_slot);
  assign b_last   = (b_rest == '0);
  assign out_fire = b_v_r && out_chan.ready;
  assign b_free   = !b_v_r || (out_chan.ready && b_last);
  // A request without results leaves the second stage at once.
  assign s1_done  = s1_v_r && ((s1_mask == '0) || b_free);
  assign b_load   = s1_v_r && (s1_mask != '0) && b_free;

  assign res_row = (b_slot == SLOT_ABOVE_PREV || b_slot == SLOT_ABOVE_END)
                 ? b_row_r - ROW_W'(1) : b_row_r;
  assign res_col = (b_slot == SLOT_ABOVE_PREV || b_slot == SLOT_LAST_PREV)
                 ? b_col_r - COL_W'(1) : b_col_r;

  assign out_chan.valid       = b_v_r;
  assign out_chan.out_row     = OUT_POS_W'(res_row);
  assign out_chan.out_col     = OUT_POS_W'(res_col);
  assign out_chan.next_alive  = b_alive_r[b_slot];
  assign out_chan.last_of_run = b_last;
  assign out_chan.frame_done  = (b_slot == SLOT_LAST_END);

  // ---------------------------------------------------------------------------
  // Input handshake: a new request can enter in the same cycle as the second stage
  // drains, so the stream keeps flowing unless a pending result has to wait for
  // a free result register.
  assign in_chan.ready = (rs_state_r == RS_IDLE) && !need_resync && (!s1_v_r || s1_done);
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    rot_nxt = rot_r;
    if (in_fire) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_sat + ROW_W'(1);
        rot_nxt = store_index(rot_r, OFF_OLDER);
      end else begin
        col_nxt = col_sat + COL_W'(1);
        row_nxt = row_sat;
      end
    end else if (rs_commit) begin
      col_nxt = col_sat;
    end

    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_done) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end

    if (b_load) begin
      b_v_nxt    = 1'b1;
      b_mask_nxt = s1_mask;
    end else if (out_fire) begin
      b_v_nxt    = !b_last;
      b_mask_nxt = b_rest;
    end else begin
      b_v_nxt    = b_v_r;
      b_mask_nxt = b_mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      rot_r      <= '0;
      rs_state_r <= RS_IDLE;
      s1_v_r     <= 1'b0;
      b_v_r      <= 1'b0;
      b_mask_r   <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      rot_r      <= rot_nxt;
      rs_state_r <= rs_state_nxt;
      s1_v_r     <= s1_v_nxt;
      b_v_r      <= b_v_nxt;
      b_mask_r   <= b_mask_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cell_r     <= in_chan.cell_alive;
      s1_row_r      <= row_sat;
      s1_col_r      <= col_sat;
      s1_row_end_r  <= row_end;
      s1_last_row_r <= last_row;
      s1_rot_r      <= rot_r;
    end
    if (s1_done) begin
      win2_r <= win1_r;
      win1_r <= col_c;
    end else begin
      if (win2_from_ram) begin
        win2_r <= col_rd;
      end
      if (win1_from_ram) begin
        win1_r <= col_rd;
      end
    end
    if (b_load) begin
      b_row_r   <= s1_row_r;
      b_col_r   <= s1_col_r;
      b_alive_r <= s1_alive;
    end
  end

endmodule

/* src/lgs_ram.sv */
// Generic simple dual-port RAM with a registered, enabled read.
module lgs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/lgs_checker.sv */
// Port-level checker of the life generation stencil and its bind statement.
`include "life_generation_stencil_defines.svh"

module lgs_checker import lgs_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  out_valid,
  input logic  out_ready,
  input opos_t out_row,
  input opos_t out_col,
  input logic  next_alive,
  input logic  last_of_run,
  input logic  frame_done
);

  // The final cell of a generation always closes its request's run.
  `LGS_ASSERT_IMP(a_done_closes_run, out_valid && frame_done, last_of_run, "frame_done without last_of_run")

  // Results of one request follow each other without a gap.
  `LGS_ASSERT_NXT(a_run_continues, out_valid && out_ready && !last_of_run, out_valid, "gap inside a run of results")

  // Within a run the row stays or moves down by one.
  `LGS_ASSERT_NXT(a_run_rows, out_valid && out_ready && !last_of_run, out_row == $past(out_row) || out_row == OUT_POS_W'($past(out_row) + OUT_POS_W'(1)), "row jump inside a run")

  // A stalled result is held unchanged.
  `LGS_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable({out_row, out_col, next_alive, last_of_run, frame_done}), "stalled result changed")

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_row     (out_chan.out_row),
  .out_col     (out_chan.out_col),
  .next_alive  (out_chan.next_alive),
  .last_of_run (out_chan.last_of_run),
  .frame_done  (out_chan.frame_done)
);
